// ===== rtl/gcd_pkg.sv =====
`timescale 1ns / 1ps

package gcd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;

    localparam int LAT_W    = 24;
    localparam int LON_W    = 25;
    localparam int DEG_W    = 26;
    localparam int RADIUS_W = 16;
    localparam int DIST_W   = 26;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;

    // cordic datapath, phase word, q30 values, square root operand
    localparam int CW    = 34;
    localparam int PH_W  = 32;
    localparam int Q_W   = 32;
    localparam int REM_W = 62;

    typedef logic signed [CW-1:0] cdata_t;

    localparam cdata_t CORDIC_GAIN  = 34'sd652032874;
    localparam cdata_t QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sd1073741824;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        34'd536870912, 34'd316933406, 34'd167458907, 34'd85004756, 34'd42667331,
        34'd21354465, 34'd10679838, 34'd5340245, 34'd2670163, 34'd1335087,
        34'd667544, 34'd333772, 34'd166886, 34'd83443, 34'd41722,
        34'd20861, 34'd10430, 34'd5215, 34'd2608, 34'd1304,
        34'd652, 34'd326, 34'd163, 34'd81, 34'd41,
        34'd20, 34'd10, 34'd5, 34'd3, 34'd1
    };

endpackage

// ===== rtl/gcd_phase_conv.sv =====
`timescale 1ns / 1ps

module gcd_phase_conv #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [gcd_pkg::DEG_W-1:0] deg,
    output logic [gcd_pkg::PH_W-1:0]         phase
);
    import gcd_pkg::*;

    localparam int SHIFT = 32 - ANGLE_FRAC_BITS;
    // floor(x * 2^SHIFT / 360) == (x * RECIP) >> 35 for every 26 bit x
    localparam logic [63:0] RECIP = ((64'd1 << (35 + SHIFT)) + 64'd359) / 64'd360;
    localparam logic [25:0] RECIP_LO = RECIP[25:0];
    localparam logic [25:0] RECIP_HI = RECIP[51:26];

    logic [DEG_W-1:0] mag_reg;
    logic             neg_reg;
    logic             neg2_reg;
    logic [51:0]      plo_reg;
    logic [51:0]      phi_reg;
    logic [52:0]      acc;
    logic [PH_W-1:0]  quo;
    logic [PH_W-1:0]  phase_reg;
    logic [PH_W-1:0]  phase_next;

    always_comb
    begin
        acc        = {1'b0, phi_reg} + 53'(plo_reg[51:26]);
        quo        = acc[40:9];
        phase_next = neg2_reg ? (~quo + 32'd1) : quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= deg[DEG_W-1] ? DEG_W'(-deg) : DEG_W'(deg);
            neg_reg   <= deg[DEG_W-1];
            plo_reg   <= mag_reg * RECIP_LO;
            phi_reg   <= mag_reg * RECIP_HI;
            neg2_reg  <= neg_reg;
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== rtl/gcd_cordic_cell.sv =====
`timescale 1ns / 1ps

module gcd_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0,
    parameter int TAG_W  = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  gcd_pkg::cdata_t      x_in,
    input  gcd_pkg::cdata_t      y_in,
    input  gcd_pkg::cdata_t      z_in,
    input  logic [TAG_W-1:0]     tag_in,
    output gcd_pkg::cdata_t      x_out,
    output gcd_pkg::cdata_t      y_out,
    output gcd_pkg::cdata_t      z_out,
    output logic [TAG_W-1:0]     tag_out
);
    import gcd_pkg::*;

    localparam cdata_t ANGLE = cdata_t'(ATAN_TURNS[STEP]);

    cdata_t dx;
    cdata_t dy;
    logic   pos;
    cdata_t x_next;
    cdata_t y_next;
    cdata_t z_next;
    cdata_t x_reg;
    cdata_t y_reg;
    cdata_t z_reg;
    logic [TAG_W-1:0] tag_reg;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (VECTOR)
        begin
            // drive y toward zero
            pos = y_in > 0;
            if (pos)
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + ANGLE;
            end
            else
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - ANGLE;
            end
        end
        else
        begin
            // drive z toward zero
            pos = z_in >= 0;
            if (pos)
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - ANGLE;
            end
            else
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + ANGLE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

// ===== rtl/gcd_sqrt_cell.sv =====
`timescale 1ns / 1ps

module gcd_sqrt_cell #(
    parameter int STEP  = 0,
    parameter int TAG_W = 32
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [gcd_pkg::REM_W-1:0]   v_in,
    input  logic [gcd_pkg::REM_W-1:0]   r_in,
    input  logic [TAG_W-1:0]            tag_in,
    output logic [gcd_pkg::REM_W-1:0]   v_out,
    output logic [gcd_pkg::REM_W-1:0]   r_out,
    output logic [TAG_W-1:0]            tag_out
);
    import gcd_pkg::*;

    localparam logic [REM_W-1:0] BIT = REM_W'(1) << (60 - 2 * STEP);

    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] v_next;
    logic [REM_W-1:0] r_next;
    logic [REM_W-1:0] v_reg;
    logic [REM_W-1:0] r_reg;
    logic [TAG_W-1:0] tag_reg;

    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            tag_reg <= tag_in;
        end
    end

    assign v_out   = v_reg;
    assign r_out   = r_reg;
    assign tag_out = tag_reg;

endmodule

// ===== rtl/great_circle_distance.sv =====
`timescale 1ns / 1ps

// Great-circle distance by the spherical law of cosines, fully pipelined: one request
// enters per clock while nothing stalls and passes through degree-to-phase conversion,
// the sin/cos rotator chain, the products and clamp, the square root chain, the acos
// vectoring chain and the radius scaling, in that order. The whole pipeline holds
// while a result waits on out_stall. Positions out of range give position_invalid
// with arc_distance zero. The radius in km resets to 6371 and is written through cfg_wr_en /
// cfg_wr_data; the user must do so only while no request is in flight (not enforced).
module great_circle_distance #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [gcd_pkg::LAT_W-1:0]   lat_a,
    input  logic signed [gcd_pkg::LON_W-1:0]   lon_a,
    input  logic signed [gcd_pkg::LAT_W-1:0]   lat_b,
    input  logic signed [gcd_pkg::LON_W-1:0]   lon_b,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gcd_pkg::DIST_W-1:0]         arc_distance,
    output logic                               position_invalid,
    input  logic                               cfg_wr_en,
    input  logic [gcd_pkg::RADIUS_W-1:0]       cfg_wr_data
);
    import gcd_pkg::*;

    localparam int PH_LAT  = 3;
    localparam int ROT_LAT = 1 + CORDIC_STEPS;
    localparam int MUL_LAT = 4;
    localparam int VEC_LAT = 1 + CORDIC_STEPS;
    localparam int OUT_LAT = 2;
    localparam int LAT = PH_LAT + ROT_LAT + MUL_LAT + SQRT_STEPS + VEC_LAT + OUT_LAT;

    localparam logic signed [33:0] LAT_LIM = 34'sd90 <<< ANGLE_FRAC_BITS;
    localparam logic signed [33:0] LON_LIM = 34'sd180 <<< ANGLE_FRAC_BITS;

    logic en;
    logic bad;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] bad_reg;
    logic [RADIUS_W-1:0] radius_reg;

    logic signed [33:0] la_x;
    logic signed [33:0] lb_x;
    logic signed [33:0] oa_x;
    logic signed [33:0] ob_x;
    logic signed [DEG_W-1:0] deg [3];
    logic [PH_W-1:0] ph [3];

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        la_x = 34'(lat_a);
        lb_x = 34'(lat_b);
        oa_x = 34'(lon_a);
        ob_x = 34'(lon_b);
        bad  = (la_x < -LAT_LIM) || (la_x > LAT_LIM) || (lb_x < -LAT_LIM) || (lb_x > LAT_LIM)
            || (oa_x < -LON_LIM) || (oa_x > LON_LIM) || (ob_x < -LON_LIM) || (ob_x > LON_LIM);
        deg[0] = DEG_W'(lat_a);
        deg[1] = DEG_W'(lat_b);
        deg[2] = DEG_W'(lon_b) - DEG_W'(lon_a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            bad_reg    <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
                bad_reg <= {bad_reg[LAT-2:0], bad};
            end
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
        end
    end

    // sin/cos of lat a, lat b and the longitude difference
    cdata_t rot_x [3][CORDIC_STEPS+1];
    cdata_t rot_y [3][CORDIC_STEPS+1];
    cdata_t rot_z [3][CORDIC_STEPS+1];
    logic   rot_f [3][CORDIC_STEPS+1];
    logic signed [Q_W-1:0] cos_v [3];
    logic signed [Q_W-1:0] sin_v [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_angle
        logic [PH_W-1:0] ph_q;
        logic [PH_W-1:0] ph_adj;
        logic            flip;
        cdata_t          z0_reg;
        logic            flip0_reg;

        gcd_phase_conv #(
            .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
        ) u_phase (
            .clk  (clk),
            .en   (en),
            .deg  (deg[a]),
            .phase(ph[a])
        );

        // fold phases in the left half-plane by a half turn
        always_comb
        begin
            ph_q   = ph[a] + 32'h4000_0000;
            flip   = ph_q[31];
            ph_adj = flip ? (ph[a] + 32'h8000_0000) : ph[a];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z0_reg    <= CW'(signed'(ph_adj));
                flip0_reg <= flip;
            end
        end

        assign rot_x[a][0] = CORDIC_GAIN;
        assign rot_y[a][0] = '0;
        assign rot_z[a][0] = z0_reg;
        assign rot_f[a][0] = flip0_reg;

        for (genvar s = 0; s < CORDIC_STEPS; s++)
        begin : g_step
            gcd_cordic_cell #(
                .STEP  (s),
                .VECTOR(1'b0),
                .TAG_W (1)
            ) u_cell (
                .clk    (clk),
                .en     (en),
                .x_in   (rot_x[a][s]),
                .y_in   (rot_y[a][s]),
                .z_in   (rot_z[a][s]),
                .tag_in (rot_f[a][s]),
                .x_out  (rot_x[a][s+1]),
                .y_out  (rot_y[a][s+1]),
                .z_out  (rot_z[a][s+1]),
                .tag_out(rot_f[a][s+1])
            );
        end

        always_comb
        begin
            cos_v[a] = rot_f[a][CORDIC_STEPS] ? Q_W'(-rot_x[a][CORDIC_STEPS])
                                               : Q_W'(rot_x[a][CORDIC_STEPS]);
            sin_v[a] = rot_f[a][CORDIC_STEPS] ? Q_W'(-rot_y[a][CORDIC_STEPS])
                                               : Q_W'(rot_y[a][CORDIC_STEPS]);
        end
    end

    // cosine sum: sa*sb + ca*cb*cd, clamped to [-1, 1]
    logic signed [63:0] ss_full;
    logic signed [63:0] cab_full;
    logic signed [63:0] cc_full;
    logic signed [63:0] sq_full;
    logic signed [Q_W:0] sum;
    logic signed [Q_W-1:0] c_next;
    logic signed [Q_W-1:0] ss_reg;
    logic signed [Q_W-1:0] cab_reg;
    logic signed [Q_W-1:0] cd_reg;
    logic signed [Q_W-1:0] ss2_reg;
    logic signed [Q_W-1:0] cc_reg;
    logic signed [Q_W-1:0] c_reg;
    logic signed [Q_W-1:0] c2_reg;
    logic [REM_W-1:0] rem_reg;

    always_comb
    begin
        ss_full  = sin_v[0] * sin_v[1];
        cab_full = cos_v[0] * cos_v[1];
        cc_full  = cab_reg * cd_reg;
        sum      = (Q_W+1)'(ss2_reg) + (Q_W+1)'(cc_reg);
        if (sum > (Q_W+1)'(ONE_Q30))
        begin
            c_next = ONE_Q30;
        end
        else if (sum < -(Q_W+1)'(ONE_Q30))
        begin
            c_next = -ONE_Q30;
        end
        else
        begin
            c_next = Q_W'(sum);
        end
        sq_full = c_reg * c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg  <= Q_W'(ss_full >>> 30);
            cab_reg <= Q_W'(cab_full >>> 30);
            cd_reg  <= cos_v[2];
            ss2_reg <= ss_reg;
            cc_reg  <= Q_W'(cc_full >>> 30);
            c_reg   <= c_next;
            rem_reg <= REM_W'(64'sh1000_0000_0000_0000 - sq_full);
            c2_reg  <= c_reg;
        end
    end

    // sqrt(1 - c^2)
    logic [REM_W-1:0] sq_v [SQRT_STEPS+1];
    logic [REM_W-1:0] sq_r [SQRT_STEPS+1];
    logic [Q_W-1:0]   sq_c [SQRT_STEPS+1];

    assign sq_v[0] = rem_reg;
    assign sq_r[0] = '0;
    assign sq_c[0] = c2_reg;

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        gcd_sqrt_cell #(
            .STEP (s),
            .TAG_W(Q_W)
        ) u_cell (
            .clk    (clk),
            .en     (en),
            .v_in   (sq_v[s]),
            .r_in   (sq_r[s]),
            .tag_in (sq_c[s]),
            .v_out  (sq_v[s+1]),
            .r_out  (sq_r[s+1]),
            .tag_out(sq_c[s+1])
        );
    end

    // acos = atan2(root, c), quarter-turn start for negative c
    logic signed [Q_W-1:0] vc;
    cdata_t vt;
    cdata_t vx0_next;
    cdata_t vy0_next;
    cdata_t vz0_next;
    cdata_t vx0_reg;
    cdata_t vy0_reg;
    cdata_t vz0_reg;
    cdata_t vec_x [CORDIC_STEPS+1];
    cdata_t vec_y [CORDIC_STEPS+1];
    cdata_t vec_z [CORDIC_STEPS+1];
    logic   vec_t [CORDIC_STEPS+1];

    always_comb
    begin
        vc = signed'(sq_c[SQRT_STEPS]);
        vt = CW'(sq_r[SQRT_STEPS][Q_W-1:0]);
        if (vc < 0)
        begin
            vx0_next = vt;
            vy0_next = -CW'(vc);
            vz0_next = QUARTER_TURN;
        end
        else
        begin
            vx0_next = CW'(vc);
            vy0_next = vt;
            vz0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx0_reg <= vx0_next;
            vy0_reg <= vy0_next;
            vz0_reg <= vz0_next;
        end
    end

    assign vec_x[0] = vx0_reg;
    assign vec_y[0] = vy0_reg;
    assign vec_z[0] = vz0_reg;
    assign vec_t[0] = 1'b0;

    for (genvar s = 0; s < CORDIC_STEPS; s++)
    begin : g_vec
        gcd_cordic_cell #(
            .STEP  (s),
            .VECTOR(1'b1),
            .TAG_W (1)
        ) u_cell (
            .clk    (clk),
            .en     (en),
            .x_in   (vec_x[s]),
            .y_in   (vec_y[s]),
            .z_in   (vec_z[s]),
            .tag_in (vec_t[s]),
            .x_out  (vec_x[s+1]),
            .y_out  (vec_y[s+1]),
            .z_out  (vec_z[s+1]),
            .tag_out(vec_t[s+1])
        );
    end

    // angle to radians, then scale by the radius
    cdata_t        zf;
    logic [31:0]   zc;
    logic [63:0]   radp;
    logic [47:0]   distp;
    logic [31:0]   rad_reg;
    logic [DIST_W-1:0] dist_next;
    logic [DIST_W-1:0] dist_reg;

    always_comb
    begin
        zf = vec_z[CORDIC_STEPS];
        if (zf < 0)
        begin
            zc = '0;
        end
        else if (zf > 34'sh0_8000_0000)
        begin
            zc = 32'h8000_0000;
        end
        else
        begin
            zc = zf[31:0];
        end
        radp      = zc * TWO_PI_Q29 + 64'h8000_0000;
        distp     = rad_reg * radius_reg + 48'h10_0000;
        dist_next = bad_reg[LAT-2] ? '0 : distp[46:21];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= radp[63:32];
            dist_reg <= dist_next;
        end
    end

    assign out_valid        = vld_reg[LAT-1];
    assign position_invalid = bad_reg[LAT-1];
    assign arc_distance     = dist_reg;

endmodule

// ===== sim/great_circle_distance_tb.sv =====
`timescale 1ns / 1ps

module great_circle_distance_tb;
    import gcd_pkg::*;

    localparam int FRAC = ANGLE_FRAC_BITS_DEF;
    localparam int LATENCY = 102;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [DIST_W-1:0] arc;
        logic              bad;
    } gc_result_t;

    class distance_board;
        gc_result_t pending[$];
        int errors;

        function void note(gc_result_t r);
            pending.push_back(r);
        endfunction

        function void check(gc_result_t got, output string msg, output bit ok);
            gc_result_t want;
            ok = 1;
            msg = "";
            if (pending.size() == 0) begin
                ok = 0;
                $sformat(msg, "unexpected result dist=%0d bad=%0b", got.arc, got.bad);
                return;
            end
            want = pending.pop_front();
            if (got.arc !== want.arc || got.bad !== want.bad) begin
                ok = 0;
                $sformat(msg, "dist=%0d bad=%0b, expected dist=%0d bad=%0b",
                         got.arc, got.bad, want.arc, want.bad);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [LAT_W-1:0] lat_a = '0;
    logic signed [LON_W-1:0] lon_a = '0;
    logic signed [LAT_W-1:0] lat_b = '0;
    logic signed [LON_W-1:0] lon_b = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DIST_W-1:0] arc_distance;
    logic position_invalid;
    logic cfg_wr_en = 1'b0;
    logic [RADIUS_W-1:0] cfg_wr_data = '0;

    great_circle_distance dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .arc_distance(arc_distance), .position_invalid(position_invalid),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #6 clk = ~clk;

    distance_board board = new();
    int fail_count = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    logic [15:0] radius_model = RADIUS_RESET;

    int atan_tab[CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic logic [31:0] deg_to_phase(longint deg);
        longint t;
        t = deg * (longint'(1) << (32 - FRAC));
        t = t / 360;
        return t[31:0];
    endfunction

    function automatic void rotate(logic [31:0] ph, output longint c, output longint s);
        logic [31:0] p;
        bit flip;
        longint x, y, z, dx, dy;
        p = ph + 32'h4000_0000;
        flip = p[31];
        x = 652032874;
        y = 0;
        p = flip ? ph + 32'h8000_0000 : ph;
        z = p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint acos_phase(longint cz);
        longint unsigned rem;
        longint t, x, y, z, dx, dy;
        rem = (64'd1 << 60) - longint'(cz * cz);
        t = longint'(floor_sqrt(rem));
        x = cz; y = t; z = 0;
        if (x < 0) begin
            x = t; y = -cz; z = 1073741824;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 64'sd2147483648) z = 64'sd2147483648;
        return z;
    endfunction

    function automatic gc_result_t predict_distance(longint la, longint oa, longint lb,
                                                    longint ob);
        gc_result_t r;
        longint lat_lim, lon_lim, ca, sa, cb, sb, cd, sd, sum;
        longint unsigned rad, arc;
        lat_lim = longint'(90) << FRAC;
        lon_lim = longint'(180) << FRAC;
        if (la < -lat_lim || la > lat_lim || lb < -lat_lim || lb > lat_lim ||
            oa < -lon_lim || oa > lon_lim || ob < -lon_lim || ob > lon_lim) begin
            r.arc = '0;
            r.bad = 1'b1;
            return r;
        end
        rotate(deg_to_phase(la), ca, sa);
        rotate(deg_to_phase(lb), cb, sb);
        rotate(deg_to_phase(ob - oa), cd, sd);
        sum = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
        if (sum > 1073741824) sum = 1073741824;
        if (sum < -1073741824) sum = -1073741824;
        rad = (longint'(acos_phase(sum)) * 64'd3373259426 + 64'd2147483648) >> 32;
        arc = (rad * radius_model + 64'd1048576) >> 21;
        r.arc = arc[DIST_W-1:0];
        r.bad = 1'b0;
        return r;
    endfunction

    // accepted requests feed the scoreboard
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            board.note(predict_distance(lat_a, lon_a, lat_b, lon_b));
    end

    always @(posedge clk) begin
        gc_result_t got;
        string msg;
        bit ok;
        if (rst_n && out_valid && !out_stall) begin
            got.arc = arc_distance;
            got.bad = position_invalid;
            board.check(got, msg, ok);
            if (!ok) report(msg);
        end
    end

    always @(posedge clk) begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout");
            $display("great_circle_distance_tb: FAIL");
            $finish;
        end
    end

    // valid stays high between back-to-back requests
    task automatic send(longint la, longint oa, longint lb, longint ob);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a <= la[LAT_W-1:0];
        lon_a <= oa[LON_W-1:0];
        lat_b <= lb[LAT_W-1:0];
        lon_b <= ob[LON_W-1:0];
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_radius(logic [15:0] r);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        radius_model = r;
    endtask

    function automatic longint rand_signed(int w);
        longint v;
        v = longint'({$urandom, $urandom});
        v = v & ((longint'(1) << w) - 1);
        if (v[w-1]) v = v - (longint'(1) << w);
        return v;
    endfunction

    function automatic longint rand_in(longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    task automatic random_requests(int n);
        longint lat_lim, lon_lim;
        longint v[4];
        lat_lim = longint'(90) << FRAC;
        lon_lim = longint'(180) << FRAC;
        for (int k = 0; k < n; k++) begin
            v[0] = rand_in(lat_lim); v[1] = rand_in(lon_lim);
            v[2] = rand_in(lat_lim); v[3] = rand_in(lon_lim);
            case ($urandom_range(9))
                0: begin
                    v[0] = rand_signed(LAT_W); v[1] = rand_signed(LON_W);
                    v[2] = rand_signed(LAT_W); v[3] = rand_signed(LON_W);
                end
                1: begin
                    // near points here, antipodal points in the next case
                    v[2] = v[0];
                    v[3] = v[1] + longint'($urandom_range(64)) - 32;
                    if (v[3] > lon_lim || v[3] < -lon_lim) v[3] = v[1];
                end
                2: begin
                    v[2] = -v[0];
                    v[3] = (v[1] >= 0) ? v[1] - lon_lim : v[1] + lon_lim;
                end
                default: ;
            endcase
            send(v[0], v[1], v[2], v[3]);
        end
    endtask

    initial begin
        longint lat_lim, lon_lim;
        lat_lim = longint'(90) << FRAC;
        lon_lim = longint'(180) << FRAC;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, legal bounds, just-out-of-range, coincident, antipodal
        send(0, 0, 0, 0);
        send(lat_lim, 0, -lat_lim, 0);
        send(0, lon_lim, 0, -lon_lim);
        send(0, -lon_lim, 0, lon_lim);
        send(lat_lim, lon_lim, lat_lim, -lon_lim);
        send(lat_lim + 1, 0, 0, 0);
        send(0, 0, -lat_lim - 1, 0);
        send(0, lon_lim + 1, 0, 0);
        send(0, 0, 0, -lon_lim - 1);
        send(-8388608, -16777216, -8388608, -16777216);
        send(8388607, 16777215, 8388607, 16777215);
        send(-1, -1, -1, -1);
        send(1234567, 7654321, 1234567, 7654321);
        send(0, 0, 0, lon_lim);
        send(3000000, 100, -3000000, 100 - lon_lim);
        send(65536 * 45, 65536 * 10, 65536 * 46, 65536 * 10);

        set_radius(16'd65535);
        send(0, 0, 0, lon_lim);
        send(lat_lim, 0, -lat_lim, 0);
        send(0, 0, 1, 1);
        set_radius(16'd1);
        send(0, 0, 0, lon_lim);
        send(-1234, 5678, 4321, -8765);
        set_radius(16'd0);
        send(0, 0, 0, lon_lim);
        set_radius(RADIUS_RESET);

        random_requests(200);
        sender_idle_pct = 63;
        random_requests(150);
        sender_idle_pct = 0;
        stall_pct = 63;
        random_requests(150);
        set_radius(16'($urandom_range(1, 65535)));
        sender_idle_pct = 18;
        stall_pct = 18;
        random_requests(150);

        // long receiver hold-off so the pipeline fills and stalls the input
        sender_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_requests(150);
        join

        // pause until everything has drained, then continue
        drain();
        set_radius(16'd65535);
        random_requests(100);
        set_radius(16'($urandom_range(1, 65535)));
        stall_pct = 30;
        sender_idle_pct = 30;
        random_requests(130);

        drain();
        if (fail_count == 0 && board.pending.size() == 0)
            $display("great_circle_distance_tb: PASS");
        else
            $display("great_circle_distance_tb: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/gcd_pkg.sv
rtl/gcd_phase_conv.sv
rtl/gcd_cordic_cell.sv
rtl/gcd_sqrt_cell.sv
rtl/great_circle_distance.sv
sim/great_circle_distance_tb.sv
